FILE: src/jid_pkg.sv
// Shared types, constants and helper functions (length counting and
// checks, character classes) for the address syntax checker. No dependencies.
package jid_pkg;

    localparam int unsigned MAX_PART_LEN = 1023;
    // Counters saturate one above the limit, so they need one extra code.
    localparam int unsigned LEN_W = $clog2(MAX_PART_LEN + 2);

    localparam logic [7:0] CH_AT    = 8'h40;  // '@'
    localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef logic [LEN_W-1:0] len_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } jid_item_t;

    function automatic len_t count_up(input len_t n);
        if (n > len_t'(MAX_PART_LEN)) begin
            count_up = n;
        end else begin
            count_up = n + len_t'(1);
        end
    endfunction

    function automatic logic len_ok(input len_t n);
        len_ok = (n != '0) && (n <= len_t'(MAX_PART_LEN));
    endfunction

    function automatic logic node_char_ok(input logic [7:0] c);
        if (c <= CH_SPACE || c[7]) begin
            node_char_ok = 1'b0;
        end else begin
            // : < > ' " &
            node_char_ok = !(c inside {8'h3A, 8'h3C, 8'h3E, 8'h27, 8'h22, 8'h26});
        end
    endfunction

    function automatic logic domain_char_ok(input logic [7:0] c);
        domain_char_ok = (c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39],
                                    8'h2E, 8'h2D, 8'h5F});
    endfunction

endpackage

FILE: src/jid_scan.sv
// Per-address scan state: node/domain/resource counters and class flags.
// Depends on jid_pkg.
module jid_scan
    import jid_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step,      // one character is consumed this cycle
    input  jid_item_t item,
    output logic      verdict    // verdict including this character
);

    logic at_seen_reg,         at_seen_next;
    len_t node_len_reg,        node_len_next;
    logic node_ok_reg,         node_ok_next;
    logic slash_seen_reg,      slash_seen_next;
    len_t domain_len_reg,      domain_len_next;
    logic domain_ok_reg,       domain_ok_next;
    len_t res_len_reg,         res_len_next;

    logic [7:0] c;

    assign c = item.byte_value;

    always_comb begin
        at_seen_next    = at_seen_reg;
        node_len_next   = node_len_reg;
        node_ok_next    = node_ok_reg;
        slash_seen_next = slash_seen_reg;
        domain_len_next = domain_len_reg;
        domain_ok_next  = domain_ok_reg;
        res_len_next    = res_len_reg;

        if (!at_seen_reg && c == CH_AT) begin
            // first '@': what came before was the node, restart the domain side
            at_seen_next    = 1'b1;
            slash_seen_next = 1'b0;
            domain_len_next = '0;
            domain_ok_next  = 1'b1;
            res_len_next    = '0;
        end else begin
            if (!at_seen_reg) begin
                node_len_next = count_up(node_len_reg);
                node_ok_next  = node_ok_reg & node_char_ok(c);
            end
            if (slash_seen_reg) begin
                res_len_next = count_up(res_len_reg);
            end else if (c == CH_SLASH) begin
                slash_seen_next = 1'b1;
            end else begin
                domain_len_next = count_up(domain_len_reg);
                domain_ok_next  = domain_ok_reg & domain_char_ok(c);
            end
        end

        verdict = (!at_seen_next || (len_ok(node_len_next) && node_ok_next))
               && len_ok(domain_len_next) && domain_ok_next
               && (!slash_seen_next || len_ok(res_len_next));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && item.last_byte)) begin
            at_seen_reg    <= 1'b0;
            node_len_reg   <= '0;
            node_ok_reg    <= 1'b1;
            slash_seen_reg <= 1'b0;
            domain_len_reg <= '0;
            domain_ok_reg  <= 1'b1;
            res_len_reg    <= '0;
        end else if (step) begin
            at_seen_reg    <= at_seen_next;
            node_len_reg   <= node_len_next;
            node_ok_reg    <= node_ok_next;
            slash_seen_reg <= slash_seen_next;
            domain_len_reg <= domain_len_next;
            domain_ok_reg  <= domain_ok_next;
            res_len_reg    <= res_len_next;
        end
    end

endmodule

FILE: src/jid_syntax_checker.sv
// Top level of the address syntax checker: input register, scan logic,
// result register. Depends on jid_pkg and jid_scan.
//
// Usage: the address is streamed one character per transfer on the s_
// channel, with s_tlast high on its final character. For each address
// exactly one result transfer leaves on the m_ channel: m_tdata[0] is 1
// when the domain and any node and resource present pass the syntax rules.
// Path: the final character passes the input register, then its verdict
// is held in the result register until taken.
// Throughput: one character per cycle, set by the update of the scan
// counters and flags, except while a final character waits (Stall).
// Stall: a finished verdict waits in the result register. Further
// characters are still taken; only a final character held in the input
// register waits until the result register is free, and then s_tready
// drops for that time.
// Reset: aresetn (synchronous, active low) clears the valid flags of
// both registers and the scan state, then waits for the first character.
module jid_syntax_checker
    import jid_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] byte_value
    input  logic       s_tlast,   // last_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] address_valid, [7:1] zero
);

    logic      in_valid_reg;
    jid_item_t in_item_reg;
    logic      out_valid_reg;
    logic      out_ok_reg;
    logic      advance;
    logic      verdict;

    // A final character can only move on when the result slot is free or being emptied.
    assign advance  = in_valid_reg &&
                      (!in_item_reg.last_byte || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.byte_value <= s_tdata;
            in_item_reg.last_byte  <= s_tlast;
        end
    end

    jid_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_item_reg),
        .verdict (verdict)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_item_reg.last_byte) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_item_reg.last_byte) begin
            out_ok_reg <= verdict;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_ok_reg};

endmodule
